// ===== hdl/mqts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqts_pkg: shared types for the multi-queue task scheduler
// Request and result payloads, request kinds and result status codes.
// ----------------------------------------------------------------------------
package mqts_pkg;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_YIELD = 2'd1,
    KIND_NEXT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTREADY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  queue_select;
    logic [15:0] task_id;
    logic        task_ready;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_task;
    logic [2:0]  from_queue;
    logic [7:0]  total_pending;
  } rsp_t;

endpackage

// ===== hdl/multi_queue_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_task_scheduler: round-robin / priority multi-queue scheduler
// Task queues held as rings in one store; add, yield and next requests.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid_i/in_stall_o in_data_i (req_t)
// out       output     out_valid_o/out_stall_i out_data_o (rsp_t)
// cfg       input      cfg_we_i             cfg_wdata_i (select_mode)
//
// Each request passes through the engine in steps: update of heads and counts,
// read of the task store, then the result register. The store read comes after
// the pointer update. A two-entry queue takes new requests while a result
// waits. Reset clears heads, counts, pointer and mode; the task store is not
// cleared. A stalled result holds the engine.
// ----------------------------------------------------------------------------
module multi_queue_task_scheduler #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mqts_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mqts_pkg::rsp_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i
);
  import mqts_pkg::*;

  logic mode_q;
  logic q_valid, q_pop;
  req_t q_data;

  // hold the scheduling mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  mqts_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  mqts_back #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni, .mode_i(mode_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );

`ifndef SYNTHESIS
  a_pop_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty request queue");
  a_pop_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop) else $error("engine took two requests back to back");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.out_task == '0)
    else $error("task reported on failed request");
`endif
endmodule

// ===== hdl/mqts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqts_front: request intake
// Writes each accepted request into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module mqts_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mqts_pkg::req_t  in_data_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output mqts_pkg::req_t  q_data_o
);
  import mqts_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// ===== hdl/mqts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqts_back: queue engine
// Chooses the queue, updates head and count, reads or writes the task store,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module mqts_back #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  mqts_pkg::req_t  q_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mqts_pkg::rsp_t  out_data_o
);
  import mqts_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} state_e;

  state_e          state_q;
  logic [15:0]     store_q [NUM_QUEUES * QUEUE_DEPTH];
  logic [DW-1:0]   head_q  [NUM_QUEUES];
  logic [CW-1:0]   count_q [NUM_QUEUES];
  logic [QW-1:0]   rot_q;
  logic [TW-1:0]   total_q;
  logic [AW-1:0]   raddr_q;
  logic [15:0]     rd_task_q;
  logic            rd_hit_q;
  rsp_t            rsp_q;

  // queue choice
  logic [NUM_QUEUES-1:0] nonempty;
  logic [QW-1:0]         pick;
  logic                  found;
  logic [QW-1:0]         start;
  logic [QW:0]           idx;

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) nonempty[i] = (count_q[i] != '0);
    found = |nonempty;
    start = (int'(rot_q) < NUM_QUEUES) ? rot_q : '0;
    pick  = '0;
    idx   = '0;
    if (mode_i) begin
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
        if (nonempty[i]) pick = QW'(i);
      end
    end else begin
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
        idx = (QW + 1)'(start) + (QW + 1)'(i);
        if (int'(idx) >= NUM_QUEUES) idx = idx - (QW + 1)'(NUM_QUEUES);
        if (nonempty[idx[QW-1:0]]) pick = idx[QW-1:0];
      end
    end
  end

  logic [QW-1:0] qs;
  logic          qs_ok;
  logic [DW-1:0] slot;
  logic [DW:0]   sum;
  logic [QW-1:0] nxt;

  always_comb begin
    qs    = QW'(q_data_i.queue_select);
    qs_ok = (int'(q_data_i.queue_select) < NUM_QUEUES);
    sum   = {1'b0, head_q[qs]} + (DW + 1)'(count_q[qs]);
    if (int'(sum) >= QUEUE_DEPTH) sum = sum - (DW + 1)'(QUEUE_DEPTH);
    slot  = sum[DW-1:0];
    nxt   = (int'(pick) == NUM_QUEUES - 1) ? '0 : pick + 1'b1;
  end

  logic [DW-1:0] hm1;
  always_comb begin
    hm1 = (head_q[qs] == '0) ? DW'(QUEUE_DEPTH - 1) : head_q[qs] - 1'b1;
  end

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = (state_q == S_DONE);

  // only a successful next carries a task out
  always_comb begin
    out_data_o = rsp_q;
    if (rd_hit_q) out_data_o.out_task = rd_task_q;
  end

  // store write port
  logic          wen;
  logic [AW-1:0] waddr;
  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    if (q_pop_o && q_data_i.task_ready && qs_ok &&
        int'(count_q[qs]) < QUEUE_DEPTH &&
        (q_data_i.kind == KIND_ADD || q_data_i.kind == KIND_YIELD)) begin
      wen   = 1'b1;
      waddr = AW'(qs) * AW'(QUEUE_DEPTH) +
              AW'((q_data_i.kind == KIND_ADD) ? slot : hm1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) store_q[waddr] <= q_data_i.task_id;
    if (state_q == S_READ) rd_task_q <= store_q[raddr_q];
    if (q_pop_o) raddr_q <= AW'(pick) * AW'(QUEUE_DEPTH) + AW'(head_q[pick]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rot_q    <= '0;
      total_q  <= '0;
      rd_hit_q <= 1'b0;
      rsp_q    <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: if (q_pop_o) begin
          state_q  <= S_READ;
          rd_hit_q <= (q_data_i.kind == KIND_NEXT) && found;
          rsp_q.from_queue <= ((q_data_i.kind == KIND_NEXT) && found) ? 3'(pick) : 3'd0;
          unique case (q_data_i.kind) inside
            KIND_ADD, KIND_YIELD: begin
              if (!q_data_i.task_ready) rsp_q.status <= ST_NOTREADY;
              else if (!wen) rsp_q.status <= ST_FULL;
              else begin
                rsp_q.status <= ST_OK;
                count_q[qs]  <= count_q[qs] + 1'b1;
                total_q      <= total_q + 1'b1;
                if (q_data_i.kind == KIND_YIELD) head_q[qs] <= hm1;
              end
            end
            KIND_NEXT: begin
              if (!mode_i) rot_q <= found ? nxt : start;
              if (found) begin
                rsp_q.status  <= ST_OK;
                count_q[pick] <= count_q[pick] - 1'b1;
                total_q       <= total_q - 1'b1;
                head_q[pick]  <= (int'(head_q[pick]) == QUEUE_DEPTH - 1) ? '0
                                 : head_q[pick] + 1'b1;
              end else begin
                rsp_q.status <= ST_EMPTY;
              end
            end
            default: rsp_q.status <= ST_NOTREADY;
          endcase
        end
        S_READ: begin
          state_q <= S_DONE;
          rsp_q.total_pending <= 8'(total_q);
        end
        S_DONE: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/multi_queue_task_scheduler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_task_scheduler_checker: scoreboard for the task scheduler
// Mirrors the queues on every accepted request and compares every result.
// ----------------------------------------------------------------------------
module multi_queue_task_scheduler_checker #(
  parameter int NQ    = 8,
  parameter int DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  mqts_pkg::req_t in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  mqts_pkg::rsp_t out_data_i,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  output int             fail_count_o,
  output int             pending_results_o,
  output int             result_count_o
);
  import mqts_pkg::*;

  logic [15:0] task_mem [NQ][DEPTH];
  int unsigned head_idx [NQ];
  int unsigned held_cnt [NQ];
  int unsigned rr_ptr;
  logic        prio_mode;
  rsp_t        sched_results [$];

  assign pending_results_o = sched_results.size();

  function automatic rsp_t schedule(req_t r);
    rsp_t        o;
    int unsigned q;
    int unsigned h;
    int unsigned sum;
    int unsigned c;
    bit          found;
    o = '0;
    found = 0;
    q = 0;
    if (r.kind == KIND_ADD || r.kind == KIND_YIELD) begin
      q = 32'(r.queue_select);
      if (!r.task_ready) begin
        o.status = ST_NOTREADY;
      end else if (q >= NQ || held_cnt[q] >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        h = head_idx[q];
        if (r.kind == KIND_ADD) begin
          task_mem[q][(h + held_cnt[q]) % DEPTH] = r.task_id;
        end else begin
          head_idx[q] = (h + DEPTH - 1) % DEPTH;
          task_mem[q][head_idx[q]] = r.task_id;
        end
        held_cnt[q]++;
        o.status = ST_OK;
      end
    end else if (r.kind == KIND_NEXT) begin
      if (prio_mode) begin
        for (int i = 0; i < NQ; i++) begin
          if (!found && held_cnt[i] > 0) begin
            found = 1;
            q = i;
          end
        end
      end else begin
        if (rr_ptr >= NQ) rr_ptr = 0;
        for (int i = 0; i < NQ; i++) begin
          c = (rr_ptr + i) % NQ;
          if (!found && held_cnt[c] > 0) begin
            found = 1;
            q = c;
          end
        end
        if (found) rr_ptr = (q + 1) % NQ;
      end
      if (found) begin
        o.out_task = task_mem[q][head_idx[q]];
        o.from_queue = 3'(q);
        head_idx[q] = (head_idx[q] + 1) % DEPTH;
        held_cnt[q]--;
        o.status = ST_OK;
      end else begin
        o.status = ST_EMPTY;
      end
    end else begin
      o.status = ST_NOTREADY;
    end
    sum = 0;
    for (int i = 0; i < NQ; i++) sum += held_cnt[i];
    o.total_pending = sum[7:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NQ; i++) begin
        head_idx[i] = 0;
        held_cnt[i] = 0;
      end
      rr_ptr = 0;
      prio_mode = 1'b0;
      fail_count_o = 0;
      result_count_o = 0;
      sched_results.delete();
    end else begin
      // Compare before predicting: a result cannot come in its own request's cycle.
      if (out_valid_i && !out_stall_i) begin
        result_count_o++;
        if (sched_results.size() == 0) begin
          $error("unexpected result %p", out_data_i);
          fail_count_o++;
        end else begin
          want = sched_results[0];
          sched_results.delete(0);
          if (out_data_i.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data_i.status);
            fail_count_o++;
          end
          if (out_data_i.out_task !== want.out_task) begin
            $error("out_task expected %0h actual %0h", want.out_task, out_data_i.out_task);
            fail_count_o++;
          end
          if (out_data_i.from_queue !== want.from_queue) begin
            $error("from_queue expected %0d actual %0d", want.from_queue,
                   out_data_i.from_queue);
            fail_count_o++;
          end
          if (out_data_i.total_pending !== want.total_pending) begin
            $error("total_pending expected %0d actual %0d", want.total_pending,
                   out_data_i.total_pending);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) prio_mode = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        sched_results.insert(sched_results.size(), schedule(in_data_i));
    end
  end

endmodule

// ===== test/multi_queue_task_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_task_scheduler_tb: stimulus and verdict for the task scheduler
// Directed corner requests, then random add/yield/next traffic in both modes
// with random idling on both channels, a long result hold-off and a drain.
// ----------------------------------------------------------------------------
module multi_queue_task_scheduler_tb;
  import mqts_pkg::*;

  localparam int NQ        = 8;
  localparam int DEPTH     = 16;
  localparam int MAX_CYCLE = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   pending_results;
  int   result_count;
  int   cycle_count = 0;
  bit   quiet_phase;   // no idling on either side
  bit   long_hold;     // receiver holds off for a long stretch
  int   sent_count;

  multi_queue_task_scheduler #(.NUM_QUEUES(NQ), .QUEUE_DEPTH(DEPTH)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  multi_queue_task_scheduler_checker #(.NQ(NQ), .DEPTH(DEPTH)) checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_results_o(pending_results),
    .result_count_o(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none when quiet.
  initial begin
    int burst;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 0;
        @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Present one request and hold it until accepted; maybe idle after it.
  task automatic send_request(input logic [1:0] k, input logic [2:0] q,
                              input logic [15:0] id, input logic rdy);
    req_t r;
    r.kind = k;
    r.queue_select = q;
    r.task_id = id;
    r.task_ready = rdy;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every result, then let the engine settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: ready adds/yields to real queues, and nexts.
  task automatic random_request;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)
      send_request(KIND_ADD, 3'($urandom_range(0, NQ - 1)), 16'($urandom), 1'b1);
    else if (sel < 50)
      send_request(KIND_YIELD, 3'($urandom_range(0, NQ - 1)), 16'($urandom), 1'b1);
    else if (sel < 90)
      send_request(KIND_NEXT, 3'($urandom), 16'($urandom), 1'($urandom));
    else
      send_request(2'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    quiet_phase = 0;
    long_hold = 0;
    sent_count = 0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty next, not ready, unused kind, extremes of the fields.
    send_request(KIND_NEXT, 3'd0, 16'h0000, 1'b0);
    send_request(KIND_ADD, 3'd7, 16'hFFFF, 1'b0);
    send_request(KIND_YIELD, 3'd0, 16'h0000, 1'b0);
    send_request(KIND_NONE, 3'd7, 16'hFFFF, 1'b1);
    send_request(KIND_ADD, 3'd0, 16'h0000, 1'b1);
    send_request(KIND_ADD, 3'd7, 16'hFFFF, 1'b1);
    send_request(KIND_YIELD, 3'd7, 16'hA5A5, 1'b1);
    send_request(KIND_ADD, 3'd3, 16'h5A5A, 1'b1);
    for (int i = 0; i < 5; i++) send_request(KIND_NEXT, 3'd0, 16'h0, 1'b1);
    // Fill queue 2 past its depth so the last requests are dropped.
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(i[0] ? KIND_YIELD : KIND_ADD, 3'd2, 16'(i), 1'b1);
    drain();

    write_mode(1'b1);
    for (int i = 0; i < 4; i++) send_request(KIND_ADD, 3'(7 - i), 16'(100 + i), 1'b1);
    for (int i = 0; i < 6; i++) send_request(KIND_NEXT, 3'd0, 16'h0, 1'b1);
    drain();

    // Random phases alternating the mode; a long hold-off in the second.
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      if (ph == 1) long_hold = 1;
      if (ph == 5) quiet_phase = 1;
      for (int i = 0; i < 120; i++) random_request();
      // Sender pauses until every result has come.
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d results over both selection modes,",
             sent_count, result_count);
    $display("including full queues, empty nexts and a long result hold-off.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
